>>> sv/plvd_pkg.sv
package plvd_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int ROTATION_STAGES = 16;
  localparam int ANGLE_WIDTH     = 16;
  localparam int TRIG_WIDTH      = 16;
  localparam int ATAN_ENTRIES    = 24;

  // CORDIC datapath: Q1.30 for x and y, 2^32 units per turn for the residual angle.
  localparam int CW = 33;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  // Arctangent of 2^-i, in 2^32 units per turn.
  localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic        [ANGLE_WIDTH-1:0] heading;
    logic signed [DATA_WIDTH-1:0]  vel_body_x;
    logic signed [DATA_WIDTH-1:0]  vel_body_y;
    logic signed [DATA_WIDTH-1:0]  yaw_rate;
    logic signed [DATA_WIDTH-1:0]  accel_x;
    logic signed [DATA_WIDTH-1:0]  accel_y;
    logic signed [DATA_WIDTH-1:0]  yaw_accel;
    logic signed [DATA_WIDTH-1:0]  progress_rate;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] world_rate_x;
    logic signed [DATA_WIDTH-1:0] world_rate_y;
    logic signed [DATA_WIDTH-1:0] heading_rate;
    logic signed [DATA_WIDTH-1:0] deriv_vel_x;
    logic signed [DATA_WIDTH-1:0] deriv_vel_y;
    logic signed [DATA_WIDTH-1:0] deriv_yaw_rate;
    logic signed [DATA_WIDTH-1:0] deriv_progress;
    logic signed [TRIG_WIDTH-1:0] cos_heading;
    logic signed [TRIG_WIDTH-1:0] sin_heading;
    logic signed [DATA_WIDTH-1:0] dxrate_dheading;
    logic signed [DATA_WIDTH-1:0] dyrate_dheading;
  } rsp_t;

  // Fields that ride along with the angle unchanged.
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] yaw_rate;
    logic signed [DATA_WIDTH-1:0] accel_x;
    logic signed [DATA_WIDTH-1:0] accel_y;
    logic signed [DATA_WIDTH-1:0] yaw_accel;
    logic signed [DATA_WIDTH-1:0] progress_rate;
  } pass_t;

  typedef struct packed {
    logic signed [CW-1:0]         x;
    logic signed [CW-1:0]         y;
    logic signed [CW-1:0]         z;
    logic                         flip;
    logic signed [DATA_WIDTH-1:0] vx;
    logic signed [DATA_WIDTH-1:0] vy;
    pass_t                        pass;
  } rot_t;

endpackage

>>> sv/planar_vehicle_dynamics_jacobian.sv
// Rotates body-frame velocity into world-frame rates and gives the heading
// Jacobian terms, one request per clock unless the output stalls. The heading
// is folded into a quarter turn either way, then a pipelined CORDIC with one
// register per rotation stage produces cosine and sine in Q1.14; the four
// products of the rotation have their own register stage before the rounded,
// saturated sums are registered at the output. Every stage holds its contents
// while stalled and empty stages fill up behind a stalled output, so requests
// are still taken while a finished result waits.
module planar_vehicle_dynamics_jacobian (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  plvd_pkg::req_t    req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output plvd_pkg::rsp_t    rsp
);

  localparam int DW = plvd_pkg::DATA_WIDTH;
  localparam int TW = plvd_pkg::TRIG_WIDTH;
  localparam int AW = plvd_pkg::ANGLE_WIDTH;
  localparam int CW = plvd_pkg::CW;
  localparam int PW = DW + TW;
  localparam int SW = PW + 1;

  localparam logic signed [AW-1:0] ANGLE_QUARTER = AW'(1 << (AW - 2));
  localparam logic signed [CW-1:0] TRIG_ROUND    = CW'(32768);
  localparam logic signed [CW-1:0] TRIG_ONE      = CW'(16384);
  localparam logic signed [SW-1:0] ROUND_Q14     = SW'(8192);
  localparam logic signed [SW-1:0] SAT_MAX       = SW'((1 << (DW - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_MIN       = ~SAT_MAX;

  typedef struct packed {
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    plvd_pkg::pass_t      pass;
  } trig_t;

  typedef struct packed {
    logic signed [PW-1:0] vx_c;
    logic signed [PW-1:0] vy_s;
    logic signed [PW-1:0] vx_s;
    logic signed [PW-1:0] vy_c;
    logic signed [TW-1:0] c;
    logic signed [TW-1:0] s;
    plvd_pkg::pass_t      pass;
  } prod_t;

  function automatic logic signed [DW-1:0] round_sat(input logic signed [SW-1:0] sum);
    logic signed [SW-1:0] r;
    r = (sum + ROUND_Q14) >>> 14;
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end else if (r < SAT_MIN) begin
      r = SAT_MIN;
    end
    return r[DW-1:0];
  endfunction

  function automatic logic signed [TW-1:0] trig_out(input logic signed [CW-1:0] v,
                                                    input logic flip);
    logic signed [CW-1:0] r;
    r = (v + TRIG_ROUND) >>> 16;
    if (r > TRIG_ONE) begin
      r = TRIG_ONE;
    end else if (r < -TRIG_ONE) begin
      r = -TRIG_ONE;
    end
    if (flip) begin
      r = -r;
    end
    return r[TW-1:0];
  endfunction

  // Fold stage.
  plvd_pkg::rot_t fold;
  plvd_pkg::rot_t fold_next;
  logic           fold_valid;
  logic           fold_ready;

  logic           rot_in_ready;
  logic           rot_valid;
  logic           rot_ready;
  plvd_pkg::rot_t rot_data;

  trig_t          trig;
  trig_t          trig_next;
  logic           trig_valid;
  logic           trig_ready;

  prod_t          prod;
  prod_t          prod_next;
  logic           prod_valid;
  logic           prod_ready;

  plvd_pkg::rsp_t rsp_next;
  logic           rsp_stage_ready;

  logic signed [AW-1:0] ang;
  logic signed [AW-1:0] ang_fold;

  always_comb begin
    ang = $signed(req.heading);
    // Adding or removing a half turn only flips the top bit of the angle.
    ang_fold = {~ang[AW-1], ang[AW-2:0]};
    fold_next.flip = (ang > ANGLE_QUARTER) || (ang < -ANGLE_QUARTER);
    if (!fold_next.flip) begin
      ang_fold = ang;
    end
    fold_next.x  = plvd_pkg::CORDIC_GAIN;
    fold_next.y  = '0;
    fold_next.z  = CW'(ang_fold) <<< 16;
    fold_next.vx = req.vel_body_x;
    fold_next.vy = req.vel_body_y;
    fold_next.pass.yaw_rate      = req.yaw_rate;
    fold_next.pass.accel_x       = req.accel_x;
    fold_next.pass.accel_y       = req.accel_y;
    fold_next.pass.yaw_accel     = req.yaw_accel;
    fold_next.pass.progress_rate = req.progress_rate;
  end

  assign fold_ready = ~fold_valid | rot_in_ready;
  assign req_ready  = fold_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fold_valid <= 1'b0;
    end else if (fold_ready) begin
      fold_valid <= req_valid;
    end
    if (fold_ready && req_valid) begin
      fold <= fold_next;
    end
  end

  plvd_rotator u_rotator (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fold_valid),
    .in_ready  (rot_in_ready),
    .in_data   (fold),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_data  (rot_data)
  );

  // Trig rounding and quadrant correction.
  always_comb begin
    trig_next.c    = trig_out(rot_data.x, rot_data.flip);
    trig_next.s    = trig_out(rot_data.y, rot_data.flip);
    trig_next.vx   = rot_data.vx;
    trig_next.vy   = rot_data.vy;
    trig_next.pass = rot_data.pass;
  end

  assign trig_ready = ~trig_valid | prod_ready;
  assign rot_ready  = trig_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_valid <= 1'b0;
    end else if (trig_ready) begin
      trig_valid <= rot_valid;
    end
    if (trig_ready && rot_valid) begin
      trig <= trig_next;
    end
  end

  // Products.
  always_comb begin
    prod_next.vx_c = PW'(trig.vx) * PW'(trig.c);
    prod_next.vy_s = PW'(trig.vy) * PW'(trig.s);
    prod_next.vx_s = PW'(trig.vx) * PW'(trig.s);
    prod_next.vy_c = PW'(trig.vy) * PW'(trig.c);
    prod_next.c    = trig.c;
    prod_next.s    = trig.s;
    prod_next.pass = trig.pass;
  end

  assign prod_ready = ~prod_valid | rsp_stage_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (prod_ready) begin
      prod_valid <= trig_valid;
    end
    if (prod_ready && trig_valid) begin
      prod <= prod_next;
    end
  end

  // Sums, rounding and saturation into the output register.
  always_comb begin
    rsp_next.world_rate_x    = round_sat(SW'(prod.vx_c) - SW'(prod.vy_s));
    rsp_next.world_rate_y    = round_sat(SW'(prod.vx_s) + SW'(prod.vy_c));
    rsp_next.dxrate_dheading = round_sat(-SW'(prod.vx_s) - SW'(prod.vy_c));
    rsp_next.dyrate_dheading = rsp_next.world_rate_x;
    rsp_next.heading_rate    = prod.pass.yaw_rate;
    rsp_next.deriv_vel_x     = prod.pass.accel_x;
    rsp_next.deriv_vel_y     = prod.pass.accel_y;
    rsp_next.deriv_yaw_rate  = prod.pass.yaw_accel;
    rsp_next.deriv_progress  = prod.pass.progress_rate;
    rsp_next.cos_heading     = prod.c;
    rsp_next.sin_heading     = prod.s;
  end

  assign rsp_stage_ready = ~rsp_valid | rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_stage_ready) begin
      rsp_valid <= prod_valid;
    end
    if (rsp_stage_ready && prod_valid) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> sv/plvd_rotator.sv
module plvd_rotator (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  plvd_pkg::rot_t      in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output plvd_pkg::rot_t      out_data
);

  localparam int N  = plvd_pkg::ROTATION_STAGES;
  localparam int CW = plvd_pkg::CW;

  plvd_pkg::rot_t stage       [N];
  logic           stage_valid [N];
  logic           stage_ready [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      localparam logic signed [CW-1:0] ATAN_I = CW'(plvd_pkg::ATAN_TABLE[i]);

      plvd_pkg::rot_t src;
      plvd_pkg::rot_t stage_next;
      logic           src_valid;
      logic           down_ready;

      if (i == 0) begin : g_first
        assign src       = in_data;
        assign src_valid = in_valid;
      end else begin : g_inner
        assign src       = stage[i-1];
        assign src_valid = stage_valid[i-1];
      end

      if (i == N - 1) begin : g_last
        assign down_ready = out_ready;
      end else begin : g_mid
        assign down_ready = stage_ready[i+1];
      end

      // A stage takes new data when it is empty or its contents move on.
      assign stage_ready[i] = ~stage_valid[i] | down_ready;

      always_comb begin
        stage_next = src;
        if (!src.z[CW-1]) begin
          stage_next.x = src.x - (src.y >>> i);
          stage_next.y = src.y + (src.x >>> i);
          stage_next.z = src.z - ATAN_I;
        end else begin
          stage_next.x = src.x + (src.y >>> i);
          stage_next.y = src.y - (src.x >>> i);
          stage_next.z = src.z + ATAN_I;
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          stage_valid[i] <= 1'b0;
        end else if (stage_ready[i]) begin
          stage_valid[i] <= src_valid;
        end
        if (stage_ready[i] && src_valid) begin
          stage[i] <= stage_next;
        end
      end
    end
  endgenerate

  assign in_ready  = stage_ready[0];
  assign out_valid = stage_valid[N-1];
  assign out_data  = stage[N-1];

endmodule
